/* rtl/rce_pkg.sv */
// Shared types, constant wiring tables and letter arithmetic for the rotor cipher engine.
// Used by rce_step_unit, rce_cell and rotor_cipher_letter_engine; depends on nothing else.
`default_nettype none

package rce_pkg;

  localparam int unsigned LETTERS   = 26;
  localparam int unsigned NUM_CELLS = 9;
  localparam int unsigned DATA_W    = 24;
  localparam int unsigned CFG_W     = 50;

  typedef logic [4:0] letter_t;

  typedef enum logic [2:0] {
    REG_ROTOR_ORDER = 3'd0,
    REG_REFLECTOR   = 3'd1,
    REG_RING        = 3'd2,
    REG_PLUG_LOW    = 3'd3,
    REG_PLUG_HIGH   = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CELL_PLUG,
    CELL_FORWARD,
    CELL_REFLECT,
    CELL_INVERSE
  } cell_kind_e;

  typedef enum logic [1:0] {
    SLOT_LEFT,
    SLOT_MIDDLE,
    SLOT_RIGHT
  } slot_e;

  typedef struct packed {
    cell_kind_e kind;
    slot_e      slot;
  } cell_op_t;

  typedef struct packed {
    logic [8:0]  rotor_order;
    logic [1:0]  refl_code;
    logic [14:0] ring_settings;
    logic [49:0] plug_pairs_low;
    logic [49:0] plug_pairs_high;
  } cfg_t;

  // One item as it travels down the chain: the letter, the windows to report
  // and the wiring offset of each rotor.
  typedef struct packed {
    logic    encipher;
    letter_t letter;
    letter_t win_l;
    letter_t win_m;
    letter_t win_r;
    letter_t sh_l;
    letter_t sh_m;
    letter_t sh_r;
  } item_t;

  // Order of the substitution cells from entry to exit.
  localparam cell_op_t CELL_OPS [NUM_CELLS] = '{
    '{kind: CELL_PLUG,    slot: SLOT_RIGHT},
    '{kind: CELL_FORWARD, slot: SLOT_RIGHT},
    '{kind: CELL_FORWARD, slot: SLOT_MIDDLE},
    '{kind: CELL_FORWARD, slot: SLOT_LEFT},
    '{kind: CELL_REFLECT, slot: SLOT_LEFT},
    '{kind: CELL_INVERSE, slot: SLOT_LEFT},
    '{kind: CELL_INVERSE, slot: SLOT_MIDDLE},
    '{kind: CELL_INVERSE, slot: SLOT_RIGHT},
    '{kind: CELL_PLUG,    slot: SLOT_RIGHT}
  };

  // Wiring strings: the first character sits in the top byte.
  localparam logic [8*LETTERS-1:0] ROTOR_WIRING [5] = '{
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
    "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO",
    "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK"
  };

  localparam logic [8*LETTERS-1:0] REFLECTOR_WIRING [3] = '{
    "EJMZALYXVBWFCRQUONTSPIKHGD",
    "YRUHQSLDPXNGOKMIEBFZCWVJAT",
    "FVPJIAOYEDRZXWGCTKUQSBNMHL"
  };

  localparam letter_t TURNOVER [5] = '{5'd16, 5'd4, 5'd21, 5'd9, 5'd25};

  function automatic letter_t sat25(input logic [4:0] v);
    return (v > 5'd25) ? 5'd25 : v;
  endfunction

  function automatic logic [2:0] wheel_sel(input logic [2:0] code);
    return (code > 3'd4) ? 3'd4 : code;
  endfunction

  function automatic logic [1:0] refl_sel(input logic [1:0] code);
    return (code > 2'd2) ? 2'd2 : code;
  endfunction

  function automatic letter_t add26(input letter_t a, input letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'd26) begin
      s = s - 6'd26;
    end
    return s[4:0];
  endfunction

  // Wraps modulo 32 on the way; the true result is below 26 so it comes out exact.
  function automatic letter_t sub26(input letter_t a, input letter_t b);
    return (a >= b) ? (a - b) : (a + 5'd26 - b);
  endfunction

  function automatic letter_t wire_char(input logic [8*LETTERS-1:0] w, input letter_t i);
    logic [7:0] ch;
    ch = w[8*(LETTERS-1-int'(i)) +: 8];
    return letter_t'(ch - 8'd65);
  endfunction

  function automatic letter_t fwd_map(input logic [2:0] wheel, input letter_t c,
                                      input letter_t sh);
    return sub26(wire_char(ROTOR_WIRING[wheel], add26(c, sh)), sh);
  endfunction

  // Inverse wiring: a compare against every contact of the selected rotor.
  function automatic letter_t inv_map(input logic [2:0] wheel, input letter_t c,
                                      input letter_t sh);
    letter_t t;
    letter_t j;
    t = add26(c, sh);
    j = '0;
    for (int k = 0; k < LETTERS; k++) begin
      if (wire_char(ROTOR_WIRING[wheel], letter_t'(k)) == t) begin
        j = letter_t'(k);
      end
    end
    return sub26(j, sh);
  endfunction

  function automatic letter_t reflect(input logic [1:0] refl, input letter_t c);
    return wire_char(REFLECTOR_WIRING[refl], c);
  endfunction

  // Plugboard swap; the lowest-numbered usable pair holding the letter wins.
  function automatic letter_t plug_swap(input letter_t c, input logic [49:0] low,
                                        input logic [49:0] high);
    logic [99:0] pairs;
    letter_t     a;
    letter_t     b;
    letter_t     r;
    pairs = {high, low};
    r = c;
    for (int k = 9; k >= 0; k--) begin
      a = pairs[10*k +: 5];
      b = pairs[10*k+5 +: 5];
      if (a != b && a <= 5'd25 && b <= 5'd25) begin
        if (c == a) begin
          r = b;
        end else if (c == b) begin
          r = a;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/rotor_cipher_letter_engine.sv */
// Top level of the three-rotor cipher letter engine: configuration registers, the
// stepping stage and the chain of substitution cells. Depends on rce_pkg, rce_step_unit, rce_cell.
//
// Usage:
//   Input items arrive on s_axis; tuser is the action (0 encipher, 1 load windows) and
//   tdata carries the letter and the three load positions. Each item yields exactly one
//   result item on m_axis: the cipher letter (0 for a load), a flag in tuser that marks a
//   cipher letter, and the three rotor windows after the item.
//   The item goes through the stepping stage and nine cells (plugboard, right, middle and
//   left rotors, reflector, the three rotors inverse, plugboard), one register each. One item
//   is accepted per cycle while m_axis does not stall; the stepping stage updates the windows
//   in the cycle of acceptance, so items follow each other without a gap.
//   When m_axis stalls, each stage holds its item and ready backs up stage by stage; empty
//   stages still fill, so up to ten items are held before s_axis_tready_o drops.
//   Reset empties the chain, sets all windows to A and loads rotors I, II, III, reflector B,
//   rings at A and no plug pairs. The user must write registers through cfg_we_i, cfg_idx_i and
//   cfg_wdata_i only with no item in flight (unenforced); an index past the last register is ignored.
`default_nettype none

module rotor_cipher_letter_engine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [2:0]                  cfg_idx_i,
  input  wire logic [rce_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // letter_in [4:0], set_left [9:5], set_middle [14:10], set_right [19:15], zero pad
  input  wire logic [rce_pkg::DATA_W-1:0]  s_axis_tdata_i,
  // action [0]
  input  wire logic                        s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // letter_out [4:0], left_window [9:5], middle_window [14:10], right_window [19:15], zero pad
  output logic [rce_pkg::DATA_W-1:0]       m_axis_tdata_o,
  // letter_valid [0]
  output logic                             m_axis_tuser_o
);

  rce_pkg::cfg_t  cfg_q;
  rce_pkg::item_t chain_item  [rce_pkg::NUM_CELLS+1];
  logic           chain_valid [rce_pkg::NUM_CELLS+1];
  logic           chain_ready [rce_pkg::NUM_CELLS+1];
  rce_pkg::item_t last_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotor_order     <= 9'd10;
      cfg_q.refl_code       <= 2'd1;
      cfg_q.ring_settings   <= '0;
      cfg_q.plug_pairs_low  <= '0;
      cfg_q.plug_pairs_high <= '0;
    end else if (cfg_we_i) begin
      case (rce_pkg::cfg_reg_e'(cfg_idx_i))
        rce_pkg::REG_ROTOR_ORDER: cfg_q.rotor_order     <= cfg_wdata_i[8:0];
        rce_pkg::REG_REFLECTOR:   cfg_q.refl_code       <= cfg_wdata_i[1:0];
        rce_pkg::REG_RING:        cfg_q.ring_settings   <= cfg_wdata_i[14:0];
        rce_pkg::REG_PLUG_LOW:    cfg_q.plug_pairs_low  <= cfg_wdata_i;
        rce_pkg::REG_PLUG_HIGH:   cfg_q.plug_pairs_high <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rce_step_unit u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .action_i     (s_axis_tuser_i),
    .letter_i     (s_axis_tdata_i[4:0]),
    .set_left_i   (s_axis_tdata_i[9:5]),
    .set_middle_i (s_axis_tdata_i[14:10]),
    .set_right_i  (s_axis_tdata_i[19:15]),
    .out_valid_o  (chain_valid[0]),
    .out_ready_i  (chain_ready[0]),
    .out_item_o   (chain_item[0])
  );

  for (genvar k = 0; k < rce_pkg::NUM_CELLS; k++) begin : g_cell
    rce_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (rce_pkg::CELL_OPS[k]),
      .cfg_i       (cfg_q),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_item_i   (chain_item[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_item_o  (chain_item[k+1])
    );
  end

  assign chain_ready[rce_pkg::NUM_CELLS] = m_axis_tready_i;
  assign last_item                       = chain_item[rce_pkg::NUM_CELLS];

  assign m_axis_tvalid_o = chain_valid[rce_pkg::NUM_CELLS];
  assign m_axis_tuser_o  = last_item.encipher;
  // A load item reports letter A.
  assign m_axis_tdata_o  = {4'b0000, last_item.win_r, last_item.win_m, last_item.win_l,
                            last_item.encipher ? last_item.letter : 5'd0};

endmodule

`default_nettype wire

/* rtl/rce_step_unit.sv */
// Entry stage: rotor window state, stepping with the double step, window loads
// and the per-rotor wiring offsets. Depends on rce_pkg.
`default_nettype none

module rce_step_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rce_pkg::cfg_t   cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            action_i,
  input  wire rce_pkg::letter_t letter_i,
  input  wire rce_pkg::letter_t set_left_i,
  input  wire rce_pkg::letter_t set_middle_i,
  input  wire rce_pkg::letter_t set_right_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output rce_pkg::item_t       out_item_o
);

  rce_pkg::letter_t left_q, left_d;
  rce_pkg::letter_t middle_q, middle_d;
  rce_pkg::letter_t right_q, right_d;
  logic             valid_q, valid_d;
  rce_pkg::item_t   item_q, item_d;
  logic             accept;
  logic [2:0]       wheel_m, wheel_r;
  logic             mid_notch, right_notch;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  assign wheel_m     = rce_pkg::wheel_sel(cfg_i.rotor_order[5:3]);
  assign wheel_r     = rce_pkg::wheel_sel(cfg_i.rotor_order[2:0]);
  assign mid_notch   = (middle_q == rce_pkg::TURNOVER[wheel_m]);
  assign right_notch = (right_q == rce_pkg::TURNOVER[wheel_r]);

  always_comb begin
    left_d   = left_q;
    middle_d = middle_q;
    right_d  = right_q;
    if (accept) begin
      if (action_i) begin
        left_d   = rce_pkg::sat25(set_left_i);
        middle_d = rce_pkg::sat25(set_middle_i);
        right_d  = rce_pkg::sat25(set_right_i);
      end else begin
        // A middle rotor at its notch carries itself and the left rotor along.
        if (mid_notch) begin
          left_d   = rce_pkg::add26(left_q, 5'd1);
          middle_d = rce_pkg::add26(middle_q, 5'd1);
        end else if (right_notch) begin
          middle_d = rce_pkg::add26(middle_q, 5'd1);
        end
        right_d = rce_pkg::add26(right_q, 5'd1);
      end
    end

    valid_d = accept ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

    item_d.encipher = !action_i;
    item_d.letter   = rce_pkg::sat25(letter_i);
    item_d.win_l    = left_d;
    item_d.win_m    = middle_d;
    item_d.win_r    = right_d;
    item_d.sh_l     = rce_pkg::sub26(left_d, rce_pkg::sat25(cfg_i.ring_settings[14:10]));
    item_d.sh_m     = rce_pkg::sub26(middle_d, rce_pkg::sat25(cfg_i.ring_settings[9:5]));
    item_d.sh_r     = rce_pkg::sub26(right_d, rce_pkg::sat25(cfg_i.ring_settings[4:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      middle_q <= '0;
      right_q  <= '0;
      valid_q  <= 1'b0;
    end else begin
      left_q   <= left_d;
      middle_q <= middle_d;
      right_q  <= right_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

`ifndef SYNTHESIS
  a_window_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= 5'd25 && middle_q <= 5'd25 && right_q <= 5'd25)
    else $error("rotor window out of range");

  a_right_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !action_i |=> right_q == rce_pkg::add26($past(right_q), 5'd1))
    else $error("right rotor did not step on an encipher item");

  a_left_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !action_i && !mid_notch |=> left_q == $past(left_q))
    else $error("left rotor moved without a middle turnover");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(left_q) && $stable(middle_q) && $stable(right_q))
    else $error("rotor windows changed without an item");
`endif

endmodule

`default_nettype wire

/* rtl/rce_cell.sv */
// One substitution cell of the letter chain: plugboard, rotor forward, reflector or
// rotor inverse, chosen by its operation input. Depends on rce_pkg.
`default_nettype none

module rce_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rce_pkg::cell_op_t op_i,
  input  wire rce_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rce_pkg::item_t    in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rce_pkg::item_t         out_item_o
);

  logic             valid_q;
  rce_pkg::item_t   item_q, item_d;
  rce_pkg::letter_t shift;
  logic [2:0]       wheel;
  logic [1:0]       refl;
  logic             accept;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;
  assign refl        = rce_pkg::refl_sel(cfg_i.refl_code);

  always_comb begin
    case (op_i.slot)
      rce_pkg::SLOT_LEFT: begin
        shift = in_item_i.sh_l;
        wheel = rce_pkg::wheel_sel(cfg_i.rotor_order[8:6]);
      end
      rce_pkg::SLOT_MIDDLE: begin
        shift = in_item_i.sh_m;
        wheel = rce_pkg::wheel_sel(cfg_i.rotor_order[5:3]);
      end
      default: begin
        shift = in_item_i.sh_r;
        wheel = rce_pkg::wheel_sel(cfg_i.rotor_order[2:0]);
      end
    endcase

    item_d = in_item_i;
    case (op_i.kind)
      rce_pkg::CELL_PLUG: begin
        item_d.letter = rce_pkg::plug_swap(in_item_i.letter, cfg_i.plug_pairs_low,
                                           cfg_i.plug_pairs_high);
      end
      rce_pkg::CELL_FORWARD: begin
        item_d.letter = rce_pkg::fwd_map(wheel, in_item_i.letter, shift);
      end
      rce_pkg::CELL_REFLECT: begin
        item_d.letter = rce_pkg::reflect(refl, in_item_i.letter);
      end
      rce_pkg::CELL_INVERSE: begin
        item_d.letter = rce_pkg::inv_map(wheel, in_item_i.letter, shift);
      end
      default: begin
        item_d.letter = in_item_i.letter;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

/* dv/rotor_cipher_letter_engine_tb.sv */
// Self-checking testbench for rotor_cipher_letter_engine: random and directed letters and
// window loads across several machine settings, checked against an in-bench cipher model.
// Depends on rce_pkg and the engine RTL only.
`timescale 1ns / 1ps

module rotor_cipher_letter_engine_tb;

  typedef rce_pkg::letter_t letter_t;

  localparam int LETTER_COUNT = 26;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RAND_PHASES  = 9;
  localparam int PHASE_ITEMS  = 205;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef enum logic {
    ACT_ENCIPHER = 1'b0,
    ACT_LOAD     = 1'b1
  } action_e;

  typedef struct packed {
    action_e action;
    letter_t letter;
    letter_t set_l;
    letter_t set_m;
    letter_t set_r;
  } key_item_t;

  typedef struct packed {
    letter_t letter;
    logic    valid;
    letter_t win_l;
    letter_t win_m;
    letter_t win_r;
  } cipher_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [2:0]  cfg_idx_i       = '0;
  logic [49:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  rotor_cipher_letter_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Machine model: wiring tables, settings and rotor windows.
  int fwd_tab  [5][LETTER_COUNT];
  int inv_tab  [5][LETTER_COUNT];
  int refl_tab [3][LETTER_COUNT];
  int notch_pos [5] = '{16, 4, 21, 9, 25};

  logic [8:0]  cfg_order   = 9'd10;
  logic [1:0]  cfg_refl    = 2'd1;
  logic [14:0] cfg_ring    = '0;
  logic [49:0] cfg_plug_lo = '0;
  logic [49:0] cfg_plug_hi = '0;
  int win_l = 0;
  int win_m = 0;
  int win_r = 0;

  key_item_t letter_stream [$];
  cipher_t   cipher_stream [$];
  key_item_t on_wire;
  int        fail_count = 0;
  int        cycle_count = 0;
  int        burst_left = 1;
  int        gap_left = 0;
  int        rx_mode = 0;
  int        rx_left = 0;

  function automatic int clip(int v);
    return (v > 25) ? 25 : v;
  endfunction

  function automatic int wheel_of(logic [2:0] code);
    return (code > 3'd4) ? 4 : int'(code);
  endfunction

  function automatic int plugboard(int c);
    logic [99:0] pairs;
    int a;
    int b;
    pairs = {cfg_plug_hi, cfg_plug_lo};
    for (int k = 0; k < 10; k++) begin
      a = int'(pairs[10*k +: 5]);
      b = int'(pairs[10*k+5 +: 5]);
      if (a != b && a <= 25 && b <= 25) begin
        if (c == a) return b;
        if (c == b) return a;
      end
    end
    return c;
  endfunction

  // Loads the windows for a load item; else steps the rotors (double step included) and runs the letter through.
  function automatic cipher_t step_machine(key_item_t it);
    cipher_t r;
    int wl, wm, wr, refl, sl, sm, sr, c;
    r = '0;
    if (it.action == ACT_LOAD) begin
      win_l = clip(int'(it.set_l));
      win_m = clip(int'(it.set_m));
      win_r = clip(int'(it.set_r));
    end else begin
      wl = wheel_of(cfg_order[8:6]);
      wm = wheel_of(cfg_order[5:3]);
      wr = wheel_of(cfg_order[2:0]);
      refl = (cfg_refl > 2'd2) ? 2 : int'(cfg_refl);
      if (win_m == notch_pos[wm]) begin
        win_l = (win_l + 1) % LETTER_COUNT;
        win_m = (win_m + 1) % LETTER_COUNT;
      end else if (win_r == notch_pos[wr]) begin
        win_m = (win_m + 1) % LETTER_COUNT;
      end
      win_r = (win_r + 1) % LETTER_COUNT;
      sl = (win_l + LETTER_COUNT - clip(int'(cfg_ring[14:10]))) % LETTER_COUNT;
      sm = (win_m + LETTER_COUNT - clip(int'(cfg_ring[9:5]))) % LETTER_COUNT;
      sr = (win_r + LETTER_COUNT - clip(int'(cfg_ring[4:0]))) % LETTER_COUNT;
      c = plugboard(clip(int'(it.letter)));
      c = (fwd_tab[wr][(c + sr) % LETTER_COUNT] + LETTER_COUNT - sr) % LETTER_COUNT;
      c = (fwd_tab[wm][(c + sm) % LETTER_COUNT] + LETTER_COUNT - sm) % LETTER_COUNT;
      c = (fwd_tab[wl][(c + sl) % LETTER_COUNT] + LETTER_COUNT - sl) % LETTER_COUNT;
      c = refl_tab[refl][c];
      c = (inv_tab[wl][(c + sl) % LETTER_COUNT] + LETTER_COUNT - sl) % LETTER_COUNT;
      c = (inv_tab[wm][(c + sm) % LETTER_COUNT] + LETTER_COUNT - sm) % LETTER_COUNT;
      c = (inv_tab[wr][(c + sr) % LETTER_COUNT] + LETTER_COUNT - sr) % LETTER_COUNT;
      r.letter = letter_t'(plugboard(c));
      r.valid  = 1'b1;
    end
    r.win_l = letter_t'(win_l);
    r.win_m = letter_t'(win_m);
    r.win_r = letter_t'(win_r);
    return r;
  endfunction

  function automatic key_item_t key_item(action_e a, int ltr, int l, int m, int r);
    key_item_t it;
    it.action = a;
    it.letter = letter_t'(ltr);
    it.set_l  = letter_t'(l);
    it.set_m  = letter_t'(m);
    it.set_r  = letter_t'(r);
    return it;
  endfunction

  // Mostly plain letters; loads often park the middle or right rotor near a turnover.
  function automatic key_item_t random_key_item();
    key_item_t it;
    int m;
    int r;
    it = key_item(ACT_ENCIPHER, $urandom_range(0, 25), $urandom_range(0, 31),
                  $urandom_range(0, 31), $urandom_range(0, 31));
    if ($urandom_range(0, 15) == 0) it.letter = letter_t'($urandom_range(26, 31));
    if ($urandom_range(0, 9) == 0) begin
      it.action = ACT_LOAD;
      it.letter = letter_t'($urandom_range(0, 31));
      if ($urandom_range(0, 3) != 0) begin
        m = $urandom_range(0, 1) ? notch_pos[$urandom_range(0, 4)] : $urandom_range(0, 25);
        r = notch_pos[$urandom_range(0, 4)] - $urandom_range(0, 2);
        it.set_l = letter_t'($urandom_range(0, 25));
        it.set_m = letter_t'(m);
        it.set_r = letter_t'(r);
      end
    end
    return it;
  endfunction

  function automatic logic [14:0] random_ring();
    logic [14:0] v;
    for (int k = 0; k < 3; k++) begin
      v[5*k +: 5] = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(26, 31))
                                                 : 5'($urandom_range(0, 25));
    end
    return v;
  endfunction

  function automatic logic [49:0] random_plugs();
    logic [49:0] v;
    int a;
    int b;
    for (int k = 0; k < 5; k++) begin
      case ($urandom_range(0, 7))
        0: begin
          a = $urandom_range(0, 31);
          b = $urandom_range(0, 31);
        end
        1: begin
          a = $urandom_range(0, 25);
          b = a;
        end
        default: begin
          a = $urandom_range(0, 25);
          b = $urandom_range(0, 25);
        end
      endcase
      v[10*k +: 10] = {5'(b), 5'(a)};
    end
    return v;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [49:0] val);
    case (idx)
      rce_pkg::REG_ROTOR_ORDER: cfg_order   = val[8:0];
      rce_pkg::REG_REFLECTOR:   cfg_refl    = val[1:0];
      rce_pkg::REG_RING:        cfg_ring    = val[14:0];
      rce_pkg::REG_PLUG_LOW:    cfg_plug_lo = val;
      rce_pkg::REG_PLUG_HIGH:   cfg_plug_hi = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic set_machine(logic [8:0] order, logic [1:0] refl, logic [14:0] ring,
                             logic [49:0] lo, logic [49:0] hi);
    write_reg(rce_pkg::REG_ROTOR_ORDER, 50'(order));
    write_reg(rce_pkg::REG_REFLECTOR, 50'(refl));
    write_reg(rce_pkg::REG_RING, 50'(ring));
    write_reg(rce_pkg::REG_PLUG_LOW, lo);
    write_reg(rce_pkg::REG_PLUG_HIGH, hi);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Returns once every queued item has been sent and every result has come back.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (letter_stream.size() != 0 || s_axis_tvalid_i || cipher_stream.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  // Sender: bursts of items with random gaps, prediction taken at acceptance.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        cipher_stream.push_back(step_machine(on_wire));
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (letter_stream.size() > 0) begin
          on_wire = letter_stream.pop_front();
          s_axis_tdata_i  <= {4'b0, on_wire.set_r, on_wire.set_m, on_wire.set_l,
                              on_wire.letter};
          s_axis_tuser_i  <= on_wire.action;
          s_axis_tvalid_i <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result and stalls in modes that change now and then.
  always @(posedge clk_i) begin
    cipher_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (cipher_stream.size() == 0) begin
          $error("result item arrived with nothing expected: tdata %h", m_axis_tdata_o);
          fail_count++;
        end else begin
          want = cipher_stream.pop_front();
          check_field("letter_out", want.letter, m_axis_tdata_o[4:0]);
          check_field("letter_valid", want.valid, m_axis_tuser_o);
          check_field("left_window", want.win_l, m_axis_tdata_o[9:5]);
          check_field("middle_window", want.win_m, m_axis_tdata_o[14:10]);
          check_field("right_window", want.win_r, m_axis_tdata_o[19:15]);
        end
      end
      if (rx_left <= 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
        2:       m_axis_tready_i <= (cycle_count % 4 == 0);
        default: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    string wheel_txt [5];
    string refl_txt [3];
    logic [49:0] lo;
    logic [49:0] hi;
    wheel_txt[0] = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
    wheel_txt[1] = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
    wheel_txt[2] = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
    wheel_txt[3] = "ESOVPZJAYQUIRHXLNFTGKDCMWB";
    wheel_txt[4] = "VZBRGITYUPSDNHLXAWMJQOFECK";
    refl_txt[0]  = "EJMZALYXVBWFCRQUONTSPIKHGD";
    refl_txt[1]  = "YRUHQSLDPXNGOKMIEBFZCWVJAT";
    refl_txt[2]  = "FVPJIAOYEDRZXWGCTKUQSBNMHL";
    // Letters are stored as ASCII, so 65 is the code of A.
    for (int w = 0; w < 5; w++) begin
      for (int j = 0; j < LETTER_COUNT; j++) begin
        fwd_tab[w][j] = int'(wheel_txt[w][j]) - 65;
        inv_tab[w][fwd_tab[w][j]] = j;
      end
    end
    for (int w = 0; w < 3; w++) begin
      for (int j = 0; j < LETTER_COUNT; j++) refl_tab[w][j] = int'(refl_txt[w][j]) - 65;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: a load to AAA, a plain run of A, out-of-range letters and loads,
    // a wrap from Z and the double step of the middle rotor.
    @(negedge clk_i);
    letter_stream.push_back(key_item(ACT_LOAD, 0, 0, 0, 0));
    repeat (5) letter_stream.push_back(key_item(ACT_ENCIPHER, 0, 0, 0, 0));
    letter_stream.push_back(key_item(ACT_ENCIPHER, 25, 0, 0, 0));
    letter_stream.push_back(key_item(ACT_ENCIPHER, 31, 0, 0, 0));
    letter_stream.push_back(key_item(ACT_ENCIPHER, 26, 0, 0, 0));
    letter_stream.push_back(key_item(ACT_LOAD, 31, 31, 31, 31));
    letter_stream.push_back(key_item(ACT_ENCIPHER, 0, 31, 31, 31));
    letter_stream.push_back(key_item(ACT_LOAD, 0, 0, 3, 21));
    letter_stream.push_back(key_item(ACT_ENCIPHER, 12, 0, 0, 0));
    letter_stream.push_back(key_item(ACT_ENCIPHER, 7, 0, 0, 0));
    letter_stream.push_back(key_item(ACT_ENCIPHER, 19, 0, 0, 0));
    letter_stream.push_back(key_item(ACT_LOAD, 0, 25, 4, 25));
    letter_stream.push_back(key_item(ACT_ENCIPHER, 5, 0, 0, 0));
    letter_stream.push_back(key_item(ACT_LOAD, 0, 0, 0, 16));
    letter_stream.push_back(key_item(ACT_ENCIPHER, 24, 31, 31, 31));
    letter_stream.push_back(key_item(ACT_ENCIPHER, 3, 0, 0, 0));
    wait_idle();

    for (int p = 1; p <= RAND_PHASES; p++) begin
      case (p)
        1: set_machine(9'd0, 2'd0, 15'd0, {50{1'b1}}, random_plugs());
        2: set_machine(9'h1FF, 2'd3, 15'h7FFF, random_plugs(), {50{1'b1}});
        3: begin
          // Overlapping, equal and out-of-range pairs in one board.
          lo = {5'd30, 5'd7, 5'd3, 5'd26, 5'd5, 5'd5, 5'd2, 5'd0, 5'd1, 5'd0};
          hi = {5'd12, 5'd13, 5'd0, 5'd4, 5'd2, 5'd25, 5'd25, 5'd24, 5'd3, 5'd1};
          set_machine(9'o432, 2'd2, {5'd25, 5'd25, 5'd25}, lo, hi);
        end
        default: begin
          set_machine(9'($urandom_range(0, 511)), 2'($urandom_range(0, 3)), random_ring(),
                      random_plugs(), random_plugs());
          if (p == 4) begin
            // An unmapped index must leave every register alone.
            write_reg(REG_UNMAPPED, 50'({$urandom, $urandom}));
            @(posedge clk_i);
            cfg_we_i <= 1'b0;
          end
        end
      endcase
      @(negedge clk_i);
      repeat (PHASE_ITEMS) letter_stream.push_back(random_key_item());
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
